### hdl/newest_rows_sorted_keeper_top_assert.svh
// Assertion macros for the newest-rows keeper top level.
// Expects clk and rst_n to be visible where the macros are used.
`ifndef NEWEST_ROWS_SORTED_KEEPER_TOP_ASSERT_SVH
`define NEWEST_ROWS_SORTED_KEEPER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NRSK_CHECK_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nrsk check failed");

// Consequent must hold in the cycle after the antecedent.
`define NRSK_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nrsk check failed");

`endif

### hdl/nrsk_pkg.sv
// Shared types, constants and helpers for the newest-rows keeper.
// No dependencies; imported by every other module of the block except nrsk_ram.
`default_nettype none

package nrsk_pkg;

    localparam int CAPACITY = 64;
    localparam int TAG_BITS = 16;
    localparam int TIME_W   = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = TIME_W + TAG_BITS;

    // Register selects (paddr bit 3, 8-byte registers).
    localparam logic REG_ANCHOR = 1'b0;
    localparam logic REG_LIMIT  = 1'b1;

    // Result status codes.
    localparam logic [2:0] ST_BEFORE_ANCHOR = 3'd0;
    localparam logic [2:0] ST_TOO_OLD       = 3'd1;
    localparam logic [2:0] ST_KEPT          = 3'd2;
    localparam logic [2:0] ST_KEPT_EVICT    = 3'd3;
    localparam logic [2:0] ST_READ          = 3'd4;

    typedef logic [TIME_W-1:0]   time_t;
    typedef logic [TAG_BITS-1:0] tag_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    typedef struct packed {
        time_t anchor_time;
        cnt_t  max_items;
        logic  limit_wr;
        cnt_t  limit_new;
    } cfg_t;

    typedef struct packed {
        logic op_read;
        logic idx_hit;
        logic below_anchor;
        logic empty;
        logic full;
        logic t_lt;
        logic t_eq;
        logic idx_zero;
        logic out_free;
    } ctl_flags_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_READ_ISSUE,
        CMD_READ_MISS,
        CMD_READ_TAKE,
        CMD_REJECT_ANCHOR,
        CMD_INSERT_EMPTY,
        CMD_SCAN_START,
        CMD_REJECT_OLD,
        CMD_EVICT_SELF,
        CMD_EVICT_LAST,
        CMD_PLACE_ABOVE,
        CMD_SHIFT,
        CMD_PUT0,
        CMD_OUT_LOAD
    } dp_cmd_t;

    // A zero limit means one; anything above the capacity saturates.
    function automatic cnt_t limit_of(input logic [6:0] v);
        cnt_t r;
        if (v == 7'd0) begin
            r = cnt_t'(1);
        end else if (32'(v) > CAPACITY) begin
            r = cnt_t'(CAPACITY);
        end else begin
            r = cnt_t'(v);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/nrsk_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package dependency.
`default_nettype none

module nrsk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/nrsk_regs.sv
// APB-style register file holding the anchor time and the item limit.
// Depends on nrsk_pkg for the configuration struct and limit helper.
`default_nettype none

module nrsk_regs
    import nrsk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    time_t anchor_reg;
    cnt_t  limit_reg;
    logic  wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_reg <= '0;
            limit_reg  <= cnt_t'(CAPACITY);
        end
        else if (wr_en)
        begin
            unique case (paddr[3])
                REG_ANCHOR: anchor_reg <= pwdata;
                REG_LIMIT:  limit_reg  <= limit_of(pwdata[6:0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3])
            REG_ANCHOR: prdata = anchor_reg;
            REG_LIMIT:  prdata = 64'(limit_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.anchor_time = anchor_reg;
    assign cfg.max_items   = limit_reg;
    assign cfg.limit_wr    = wr_en && (paddr[3] == REG_LIMIT);
    assign cfg.limit_new   = limit_of(pwdata[6:0]);

endmodule

`default_nettype wire

### hdl/nrsk_ctrl.sv
// Sequencing state machine: decodes an item and walks the list from its tail.
// Depends on nrsk_pkg for the flag struct and datapath command codes.
`default_nettype none

module nrsk_ctrl
    import nrsk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire ctl_flags_t flags,
    output dp_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_DECODE    = 7'b0000010,
        S_RD_DATA   = 7'b0000100,
        S_SCAN_LAST = 7'b0001000,
        S_SCAN      = 7'b0010000,
        S_PUT0      = 7'b0100000,
        S_FINISH    = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (flags.op_read)
                begin
                    if (flags.idx_hit)
                    begin
                        cmd        = CMD_READ_ISSUE;
                        state_next = S_RD_DATA;
                    end
                    else
                    begin
                        cmd        = CMD_READ_MISS;
                        state_next = S_FINISH;
                    end
                end
                else if (flags.below_anchor)
                begin
                    cmd        = CMD_REJECT_ANCHOR;
                    state_next = S_FINISH;
                end
                else if (flags.empty)
                begin
                    cmd        = CMD_INSERT_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_SCAN_START;
                    state_next = S_SCAN_LAST;
                end
            end
            S_RD_DATA:
            begin
                cmd        = CMD_READ_TAKE;
                state_next = S_FINISH;
            end
            S_SCAN_LAST:
            begin
                if (flags.full)
                begin
                    if (flags.t_lt)
                    begin
                        cmd        = CMD_REJECT_OLD;
                        state_next = S_FINISH;
                    end
                    else if (flags.t_eq)
                    begin
                        cmd        = CMD_EVICT_SELF;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd        = CMD_EVICT_LAST;
                        state_next = flags.idx_zero ? S_PUT0 : S_SCAN;
                    end
                end
                else if (flags.t_lt || flags.t_eq)
                begin
                    cmd        = CMD_PLACE_ABOVE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_SHIFT;
                    state_next = flags.idx_zero ? S_PUT0 : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (flags.t_lt || flags.t_eq)
                begin
                    cmd        = CMD_PLACE_ABOVE;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd        = CMD_SHIFT;
                    state_next = flags.idx_zero ? S_PUT0 : S_SCAN;
                end
            end
            S_PUT0:
            begin
                cmd        = CMD_PUT0;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (flags.out_free)
                begin
                    cmd        = CMD_OUT_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/nrsk_dp.sv
// Datapath: captured item, list memory, scan pointer, count and result registers.
// Depends on nrsk_pkg and instantiates nrsk_ram for the sorted list.
`default_nettype none

module nrsk_dp
    import nrsk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire dp_cmd_t     cmd,
    input  wire cfg_t        cfg,
    output ctl_flags_t       flags,
    input  wire logic        op,
    input  wire logic [63:0] arrival_time,
    input  wire logic [15:0] row_tag,
    input  wire logic [5:0]  read_index,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [6:0]       kept_count,
    output logic [15:0]      evicted_tag,
    output logic             read_valid,
    output logic [63:0]      read_time,
    output logic [15:0]      read_tag
);

    // Captured item.
    logic       op_reg;
    time_t      time_reg;
    tag_t       tag_reg;
    logic [5:0] idx_reg;

    // Control state.
    cnt_t  count_reg;
    addr_t ptr_reg;
    logic  evict_reg;
    logic  out_valid_reg;

    // Pending result.
    logic [2:0] res_status_reg;
    tag_t       res_evtag_reg;
    logic       res_rvalid_reg;
    time_t      res_rtime_reg;
    tag_t       res_rtag_reg;

    // Output registers.
    logic [2:0]  out_status_reg;
    cnt_t        out_count_reg;
    tag_t        out_evtag_reg;
    logic        out_rvalid_reg;
    time_t       out_rtime_reg;
    tag_t        out_rtag_reg;

    // Memory port.
    logic                ram_we;
    addr_t               ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    addr_t               ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;
    time_t               rd_time;
    tag_t                rd_tag;
    logic                out_free;
    logic                finish_insert;

    nrsk_ram #(
        .WIDTH(WORD_W),
        .DEPTH(CAPACITY)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_time  = ram_rdata[WORD_W-1:TAG_BITS];
    assign rd_tag   = ram_rdata[TAG_BITS-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    assign flags.op_read      = op_reg;
    assign flags.idx_hit      = (32'(idx_reg) < 32'(count_reg));
    assign flags.below_anchor = (time_reg < cfg.anchor_time);
    assign flags.empty        = (count_reg == '0);
    assign flags.full         = (count_reg >= cfg.max_items);
    assign flags.t_lt         = (time_reg < rd_time);
    assign flags.t_eq         = (time_reg == rd_time);
    assign flags.idx_zero     = (ptr_reg == '0);
    assign flags.out_free     = out_free;

    // Memory write and read address selection. The read port prefetches the
    // next entry toward the head while the current one is being compared.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = addr_t'(ptr_reg + 1'b1);
        ram_wdata = {time_reg, tag_reg};
        ram_raddr = addr_t'(ptr_reg - 1'b1);
        unique case (cmd)
            CMD_READ_ISSUE:   ram_raddr = addr_t'(idx_reg);
            CMD_SCAN_START:   ram_raddr = addr_t'(count_reg - 1'b1);
            CMD_INSERT_EMPTY:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            CMD_PLACE_ABOVE:  ram_we = 1'b1;
            CMD_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
            end
            CMD_PUT0:
            begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            default:          ;
        endcase
    end

    assign finish_insert = (cmd == CMD_PLACE_ABOVE) || (cmd == CMD_PUT0);

    // Count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.limit_wr)
            begin
                if (count_reg > cfg.limit_new)
                begin
                    count_reg <= cfg.limit_new;
                end
            end
            else if (cmd == CMD_INSERT_EMPTY)
            begin
                count_reg <= cnt_t'(count_reg + 1'b1);
            end
            else if (finish_insert && !evict_reg)
            begin
                count_reg <= cnt_t'(count_reg + 1'b1);
            end

            if (cmd == CMD_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture, scan pointer and result staging.
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_CAPTURE:
            begin
                op_reg         <= op;
                time_reg       <= arrival_time;
                tag_reg        <= tag_t'(row_tag);
                idx_reg        <= read_index;
                evict_reg      <= 1'b0;
                res_status_reg <= ST_BEFORE_ANCHOR;
                res_evtag_reg  <= '0;
                res_rvalid_reg <= 1'b0;
                res_rtime_reg  <= '0;
                res_rtag_reg   <= '0;
            end
            CMD_READ_MISS:     res_status_reg <= ST_READ;
            CMD_READ_TAKE:
            begin
                res_status_reg <= ST_READ;
                res_rvalid_reg <= 1'b1;
                res_rtime_reg  <= rd_time;
                res_rtag_reg   <= rd_tag;
            end
            CMD_REJECT_ANCHOR: res_status_reg <= ST_BEFORE_ANCHOR;
            CMD_INSERT_EMPTY:  res_status_reg <= ST_KEPT;
            CMD_SCAN_START:    ptr_reg <= addr_t'(count_reg - 1'b1);
            CMD_REJECT_OLD:    res_status_reg <= ST_TOO_OLD;
            CMD_EVICT_SELF:
            begin
                res_status_reg <= ST_KEPT_EVICT;
                res_evtag_reg  <= tag_reg;
            end
            CMD_EVICT_LAST:
            begin
                evict_reg     <= 1'b1;
                res_evtag_reg <= rd_tag;
                ptr_reg       <= addr_t'(ptr_reg - 1'b1);
            end
            CMD_SHIFT:         ptr_reg <= addr_t'(ptr_reg - 1'b1);
            CMD_PLACE_ABOVE, CMD_PUT0:
            begin
                res_status_reg <= evict_reg ? ST_KEPT_EVICT : ST_KEPT;
            end
            CMD_OUT_LOAD:
            begin
                out_status_reg <= res_status_reg;
                out_count_reg  <= count_reg;
                out_evtag_reg  <= res_evtag_reg;
                out_rvalid_reg <= res_rvalid_reg;
                out_rtime_reg  <= res_rtime_reg;
                out_rtag_reg   <= res_rtag_reg;
            end
            default:           ;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign kept_count  = 7'(out_count_reg);
    assign evicted_tag = 16'(out_evtag_reg);
    assign read_valid  = out_rvalid_reg;
    assign read_time   = out_rtime_reg;
    assign read_tag    = 16'(out_rtag_reg);

endmodule

`default_nettype wire

### hdl/newest_rows_sorted_keeper_top.sv
// Top level of the newest-rows keeper: register port, controller and datapath.
// Depends on nrsk_pkg, nrsk_regs, nrsk_ctrl, nrsk_dp and the assertion macros.
//
// The block keeps up to max_items records (timestamp, tag) sorted newest first.
// Input items arrive on in_valid/in_stall; a transfer happens when in_valid is
// high and in_stall is low. op 0 offers a record, op 1 reads the entry at
// read_index. Every input item produces exactly one output transfer on
// out_valid/out_stall carrying status, kept_count, evicted_tag and read data.
// One item is worked on at a time. An insertion walks the list from its oldest
// entry toward the head, moving one entry per cycle through the single write
// port of the list memory. The output register lets the next item be accepted
// while a result is still waiting; if the receiver keeps out_stall high, the
// following item finishes its work and then waits for the output register to
// free up. Reset clears the count to zero, the anchor to zero and the limit to
// the full capacity; the list memory needs no clear. Configuration is to be
// written through the APB port only while the block is idle; the user is bound
// by this, and the block itself does not enforce it.
`default_nettype none

`include "newest_rows_sorted_keeper_top_assert.svh"

module newest_rows_sorted_keeper_top
    import nrsk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [63:0] arrival_time,
    input  wire logic [15:0] row_tag,
    input  wire logic [5:0]  read_index,
    // Output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [2:0]  status,
    output logic      [6:0]  kept_count,
    output logic      [15:0] evicted_tag,
    output logic             read_valid,
    output logic      [63:0] read_time,
    output logic      [15:0] read_tag
);

    cfg_t       cfg;
    ctl_flags_t flags;
    dp_cmd_t    cmd;

    nrsk_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nrsk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .flags    (flags),
        .cmd      (cmd)
    );

    nrsk_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .flags        (flags),
        .op           (op),
        .arrival_time (arrival_time),
        .row_tag      (row_tag),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .kept_count   (kept_count),
        .evicted_tag  (evicted_tag),
        .read_valid   (read_valid),
        .read_time    (read_time),
        .read_tag     (read_tag)
    );

    // An eviction only happens when the list is at its limit.
    `NRSK_CHECK_NOW(a_evict_at_limit, out_valid && (status == ST_KEPT_EVICT), kept_count == 7'(cfg.max_items))
    // A plain insertion never leaves more records than the limit allows.
    `NRSK_CHECK_NOW(a_kept_in_limit, out_valid && (status == ST_KEPT), (kept_count != 7'd0) && (kept_count <= 7'(cfg.max_items)))
    // Only reads report read data.
    `NRSK_CHECK_NOW(a_rvalid_on_read, out_valid && (status != ST_READ), !read_valid)
    // After taking an item the controller is still busy in the following cycle.
    `NRSK_CHECK_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for newest_rows_sorted_keeper_top: a directed table, then random
// traffic over several register settings, checked against a sorted-list predictor.
// Depends on nrsk_pkg and the block's RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nrsk_pkg::*;

    // Operation codes on the op input.
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Registers are 8 bytes apart because the anchor is 64 bits wide.
    localparam logic [3:0] ADDR_ANCHOR = {REG_ANCHOR, 3'b000};
    localparam logic [3:0] ADDR_LIMIT  = {REG_LIMIT, 3'b000};

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 150;

    typedef struct packed {
        logic       op;
        time_t      arrival_time;
        tag_t       row_tag;
        logic [5:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] kept_count;
        tag_t       evicted_tag;
        logic       read_valid;
        time_t      read_time;
        tag_t       read_tag;
    } row_outcome_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

    // One line of the directed table: either an item or a new pair of register values.
    typedef struct {
        row_kind_e    kind;
        logic [63:0]  cfg_anchor;
        logic [63:0]  cfg_limit;
        in_item_t     item;
        bit           typed;
        row_outcome_t want;
    } stim_row_t;

    // Every input starts at a known value.
    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        psel         = 1'b0;
    logic        penable      = 1'b0;
    logic        pwrite       = 1'b0;
    logic [3:0]  paddr        = '0;
    logic [63:0] pwdata       = '0;
    logic        in_valid     = 1'b0;
    logic        op           = 1'b0;
    logic [63:0] arrival_time = '0;
    logic [15:0] row_tag      = '0;
    logic [5:0]  read_index   = '0;
    logic        out_stall    = 1'b0;

    logic [63:0] prdata;
    logic        pready;
    logic        in_stall;
    logic        out_valid;
    logic [2:0]  status;
    logic [6:0]  kept_count;
    logic [15:0] evicted_tag;
    logic        read_valid;
    logic [63:0] read_time;
    logic [15:0] read_tag;

    newest_rows_sorted_keeper_top uut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall), .op(op),
        .arrival_time(arrival_time), .row_tag(row_tag), .read_index(read_index),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .kept_count(kept_count), .evicted_tag(evicted_tag), .read_valid(read_valid),
        .read_time(read_time), .read_tag(read_tag)
    );

    // Shadow copy of the kept list, newest first, plus the two registers. One spare slot
    // holds the record that is pushed out past the limit before it is dropped.
    time_t shadow_time [0:CAPACITY];
    tag_t  shadow_tag [0:CAPACITY];
    int    shadow_count  = 0;
    time_t shadow_anchor = '0;
    int    shadow_limit  = CAPACITY;

    // Outcomes predicted at each accepted input transfer, oldest first.
    row_outcome_t pending_outcomes[$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int settings_count = 0;
    int kept_seen      = 0;
    int evict_seen     = 0;
    int reject_seen    = 0;
    int read_seen      = 0;
    int hit_seen       = 0;

    int    snd_idle_pct = 0;
    int    rcv_idle_pct = 0;
    int    hold_request = 0;
    int    hold_left    = 0;
    time_t stream_clock = '0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Works out the outcome of one item on the shadow list and updates it. An offer walks
    // past every kept record that is at least as new, so equal timestamps keep their
    // arrival order; a record pushed beyond the limit is the one reported as evicted,
    // which may be the offered record itself when it ties with the oldest of a full list.
    function automatic row_outcome_t shadow_step(input in_item_t it);
        row_outcome_t r;
        int pos;
        int i;
        r = '0;
        if (it.op == OP_READ) begin
            r.status = ST_READ;
            if (int'(it.read_index) < shadow_count) begin
                r.read_valid = 1'b1;
                r.read_time  = shadow_time[it.read_index];
                r.read_tag   = shadow_tag[it.read_index];
            end
        end else if (it.arrival_time < shadow_anchor) begin
            r.status = ST_BEFORE_ANCHOR;
        end else if (shadow_count >= shadow_limit && shadow_count > 0
                     && it.arrival_time < shadow_time[shadow_count-1]) begin
            r.status = ST_TOO_OLD;
        end else begin
            pos = 0;
            while (pos < shadow_count && shadow_time[pos] >= it.arrival_time)
                pos++;
            for (i = shadow_count; i > pos; i--) begin
                shadow_time[i] = shadow_time[i-1];
                shadow_tag[i]  = shadow_tag[i-1];
            end
            shadow_time[pos] = it.arrival_time;
            shadow_tag[pos]  = it.row_tag;
            shadow_count++;
            r.status = ST_KEPT;
            if (shadow_count > shadow_limit) begin
                shadow_count--;
                r.evicted_tag = shadow_tag[shadow_count];
                r.status      = ST_KEPT_EVICT;
            end
        end
        r.kept_count = 7'(shadow_count);
        return r;
    endfunction

    function automatic stim_row_t item_row(input logic o, input time_t t, input tag_t g,
                                           input logic [5:0] x);
        stim_row_t r;
        r.kind       = ROW_ITEM;
        r.cfg_anchor = '0;
        r.cfg_limit  = '0;
        r.item       = '{o, t, g, x};
        r.typed      = 1'b0;
        r.want       = '0;
        return r;
    endfunction

    // A row whose outcome is plain from the list contents, so it is written out in full.
    function automatic stim_row_t typed_row(input logic o, input time_t t, input tag_t g,
                                            input logic [5:0] x, input logic [2:0] st,
                                            input logic [6:0] cnt, input tag_t ev,
                                            input logic rv, input time_t rt, input tag_t rg);
        stim_row_t r;
        r       = item_row(o, t, g, x);
        r.typed = 1'b1;
        r.want  = '{st, cnt, ev, rv, rt, rg};
        return r;
    endfunction

    function automatic stim_row_t cfg_row(input logic [63:0] anchor, input logic [63:0] lim);
        stim_row_t r;
        r            = item_row(OP_OFFER, '0, '0, '0);
        r.kind       = ROW_CFG;
        r.cfg_anchor = anchor;
        r.cfg_limit  = lim;
        return r;
    endfunction

    // Random traffic follows a slowly advancing stream clock above the anchor, so that
    // records mostly arrive close together and the list keeps churning, with some
    // timestamps tied to the oldest kept record, some below the anchor and some extreme.
    function automatic in_item_t random_item();
        in_item_t it;
        int pick;
        it.op      = ($urandom_range(0, 99) < 28) ? OP_READ : OP_OFFER;
        it.row_tag = tag_t'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 1) == 0 || shadow_count == 0)
            it.read_index = 6'($urandom_range(0, 63));
        else
            it.read_index = 6'($urandom_range(0, shadow_count - 1));
        stream_clock = stream_clock + 64'($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 8)
            it.arrival_time = {$urandom, $urandom};
        else if (pick < 12)
            it.arrival_time = ($urandom_range(0, 1) == 1) ? '1 : '0;
        else if (pick < 20)
            it.arrival_time = shadow_anchor - 64'($urandom_range(1, 20));
        else if (pick < 32 && shadow_count > 0)
            it.arrival_time = shadow_time[shadow_count-1];
        else
            it.arrival_time = shadow_anchor + stream_clock + 64'($urandom_range(0, 40));
        return it;
    endfunction

    function automatic void field_check(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compares one output transfer with the oldest prediction and tallies what it was.
    task automatic take_result();
        row_outcome_t want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t ns: result with no expectation waiting, status %0d", $time, status);
            mismatch_count++;
        end else begin
            want = pending_outcomes.pop_front();
            field_check("status", 64'(want.status), 64'(status));
            field_check("kept_count", 64'(want.kept_count), 64'(kept_count));
            field_check("evicted_tag", 64'(want.evicted_tag), 64'(evicted_tag));
            field_check("read_valid", 64'(want.read_valid), 64'(read_valid));
            field_check("read_time", want.read_time, read_time);
            field_check("read_tag", 64'(want.read_tag), 64'(read_tag));
        end
        case (status)
            ST_KEPT:          kept_seen++;
            ST_KEPT_EVICT:    evict_seen++;
            ST_READ:
            begin
                read_seen++;
                if (read_valid)
                    hit_seen++;
            end
            default:          reject_seen++;
        endcase
    endtask

    // Output side. Results are sampled at the edge with the values that held just before
    // it, and the stall for the next cycle is chosen at the same edge. A hold request from
    // the stimulus turns into a long run of stalled cycles, counted down here.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                take_result();
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left = hold_left - 1;
            end else if (hold_request > 0) begin
                out_stall <= 1'b1;
                hold_left = hold_request - 1;
                hold_request = 0;
            end else begin
                out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
            end
        end
    end

    // Offers one item and holds it until the block takes the transfer; the prediction is
    // made at the accepting edge, so it sees the list exactly as the block does.
    task automatic offer_item(input in_item_t it, input bit typed, input row_outcome_t want);
        row_outcome_t predicted;
        in_valid     <= 1'b1;
        op           <= it.op;
        arrival_time <= it.arrival_time;
        row_tag      <= it.row_tag;
        read_index   <= it.read_index;
        do
            @(posedge clk);
        while (in_stall);
        predicted = shadow_step(it);
        pending_outcomes.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Random gap on the input side. Without a gap the next item follows at once, so the
    // valid stays high across back-to-back transfers.
    task automatic sender_pause();
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Every item yields one result, so the block is idle once nothing is outstanding.
    task automatic wait_idle();
        if (pending_outcomes.size() != 0) begin
            in_valid <= 1'b0;
            while (pending_outcomes.size() != 0)
                @(posedge clk);
        end
    endtask

    // Writes the anchor and then the limit as two back-to-back APB transfers, the second
    // setup phase following the first access directly. A lowered limit drops the oldest
    // records of the shadow list, as it does in the block.
    task automatic write_settings(input logic [63:0] anchor, input logic [63:0] lim);
        int v;
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_ANCHOR;
        pwdata  <= anchor;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        paddr   <= ADDR_LIMIT;
        pwdata  <= lim;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_anchor = anchor;
        // Only the low seven bits count; zero means one and the capacity is the ceiling.
        v = int'(lim[6:0]);
        if (v == 0)
            v = 1;
        if (v > CAPACITY)
            v = CAPACITY;
        shadow_limit = v;
        if (shadow_count > shadow_limit)
            shadow_count = shadow_limit;
        settings_count++;
    endtask

    initial
    begin : stimulus
        stim_row_t directed_rows[$];
        int        phase_limits[PHASES];
        logic [63:0] anchor;
        int        p;
        int        n;

        // Directed table. Typed rows cover the empty list, the timestamp extremes, the
        // rejections and the tie with the oldest record of a full list; the rest is
        // left to the predictor.
        directed_rows.push_back(typed_row(OP_READ, '0, '0, 6'd0, ST_READ,
                                          7'd0, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_READ, '1, '1, 6'd63, ST_READ,
                                          7'd0, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_OFFER, '0, 16'h0000, 6'd0, ST_KEPT,
                                          7'd1, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_OFFER, '1, 16'hFFFF, 6'd0, ST_KEPT,
                                          7'd2, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_READ, '0, '0, 6'd0, ST_READ,
                                          7'd2, '0, 1'b1, '1, 16'hFFFF));
        directed_rows.push_back(typed_row(OP_READ, '0, '0, 6'd1, ST_READ,
                                          7'd2, '0, 1'b1, '0, 16'h0000));
        directed_rows.push_back(item_row(OP_OFFER, 64'd100, 16'd1, 6'd0));
        directed_rows.push_back(item_row(OP_OFFER, 64'd100, 16'd2, 6'd0));
        directed_rows.push_back(item_row(OP_READ, '0, '0, 6'd1));
        directed_rows.push_back(item_row(OP_READ, '0, '0, 6'd2));
        // Lowering the limit to three drops the record stamped zero.
        directed_rows.push_back(cfg_row(64'd50, 64'd3));
        directed_rows.push_back(typed_row(OP_OFFER, 64'd49, 16'd7, 6'd0, ST_BEFORE_ANCHOR,
                                          7'd3, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_OFFER, 64'd60, 16'd8, 6'd0, ST_TOO_OLD,
                                          7'd3, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_OFFER, 64'd100, 16'd3, 6'd0, ST_KEPT_EVICT,
                                          7'd3, 16'd3, 1'b0, '0, '0));
        directed_rows.push_back(item_row(OP_OFFER, 64'd50, 16'd9, 6'd0));
        directed_rows.push_back(item_row(OP_OFFER, 64'd200, 16'd4, 6'd0));
        directed_rows.push_back(item_row(OP_READ, '0, '0, 6'd3));
        // A zero limit behaves as one; the anchor at its top leaves only the newest time.
        directed_rows.push_back(cfg_row('1, 64'd0));
        directed_rows.push_back(typed_row(OP_OFFER, 64'hFFFF_FFFF_FFFF_FFFE, 16'd6, 6'd0,
                                          ST_BEFORE_ANCHOR, 7'd1, '0, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_OFFER, '1, 16'd5, 6'd0, ST_KEPT_EVICT,
                                          7'd1, 16'd5, 1'b0, '0, '0));
        directed_rows.push_back(typed_row(OP_READ, '0, '0, 6'd0, ST_READ,
                                          7'd1, '0, 1'b1, '1, 16'hFFFF));
        // A limit above the capacity saturates.
        directed_rows.push_back(cfg_row('0, 64'd127));
        directed_rows.push_back(item_row(OP_OFFER, '0, 16'h5A5A, 6'd0));
        directed_rows.push_back(item_row(OP_READ, '0, '0, 6'd1));
        directed_rows.push_back(item_row(OP_READ, '0, '0, 6'd63));

        phase_limits = '{64, 5, 1, 127, 17, 0, 3, 64, 40};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                write_settings(directed_rows[k].cfg_anchor, directed_rows[k].cfg_limit);
            end else begin
                offer_item(directed_rows[k].item, directed_rows[k].typed, directed_rows[k].want);
                sender_pause();
            end
        end

        // Random phases. The first three idle the receiver more than the sender, the next
        // three the other way round, and the last three run with no idling at all.
        for (p = 0; p < PHASES; p++) begin
            case (p % 4)
                0:       anchor = '0;
                1:       anchor = {$urandom, $urandom};
                2:       anchor = 64'd1000;
                default: anchor = '1 - 64'd30;
            endcase
            write_settings(anchor, 64'(phase_limits[p]));
            if (p < 3) begin
                snd_idle_pct = 13;
                rcv_idle_pct = 52;
            end else if (p < 6) begin
                snd_idle_pct = 52;
                rcv_idle_pct = 13;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            stream_clock = '0;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                // The receiver holds off long enough for the block to back up its input
                // while items keep coming; later the sender stops until all is drained.
                if (p == 1 && n == 30)
                    hold_request = 400;
                if (p == 4 && n == 75)
                    wait_idle();
                offer_item(random_item(), 1'b0, '0);
                sender_pause();
            end
        end

        wait_idle();
        // A late or spurious result would still show up within the longest insertion.
        repeat (CAPACITY + 16) @(posedge clk);

        $display("Sent %0d items over %0d register settings; results: %0d kept, %0d evicting,",
                 items_sent, settings_count, kept_seen, evict_seen);
        $display("%0d rejected, %0d reads of which %0d hit; %0d mismatches.",
                 reject_seen, read_seen, hit_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: several times the slowest legal run, including the long receiver hold.
    initial
    begin : watchdog
        #(20_000_000);
        $display("Timed out with %0d results still outstanding.", pending_outcomes.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
